/* sv/wffba_pkg.sv */
package wffba_pkg;

    localparam int unsigned FREE_SLOTS = 16;
    localparam int unsigned HDR_BYTES  = 4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] length;
        logic [31:0] position;
    } t_in_item;

    typedef struct packed {
        logic [31:0] alloc_offset;
        logic        reused;
        logic        dropped;
        logic        end_wrapped;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic [31:0] offset;
        logic [15:0] size;
    } t_entry;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_INSERT,
        CH_POP
    } t_chain_op;

    typedef struct packed {
        t_chain_op op;
        t_entry    new_entry;
    } t_chain_ctl;

    typedef struct packed {
        t_entry head;
        logic   full;
    } t_chain_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REINS
    } t_state;

endpackage

/* sv/wffba_cell.sv */
module wffba_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wffba_pkg::t_chain_ctl i_ctl,
    input  wffba_pkg::t_entry     i_left,
    input  logic                  i_left_ins,
    input  wffba_pkg::t_entry     i_right,
    output wffba_pkg::t_entry     o_entry,
    output logic                  o_ins
);

    logic        r_valid;
    logic [31:0] r_offset;
    logic [15:0] r_size;
    logic        n_valid;
    logic [31:0] n_offset;
    logic [15:0] n_size;

    // new block goes before any entry of equal or smaller size
    assign o_ins = !r_valid || (r_size <= i_ctl.new_entry.size);

    assign o_entry.valid  = r_valid;
    assign o_entry.offset = r_offset;
    assign o_entry.size   = r_size;

    always_comb begin
        n_valid  = r_valid;
        n_offset = r_offset;
        n_size   = r_size;
        case (i_ctl.op)
            wffba_pkg::CH_INSERT: begin
                if (i_left_ins) begin
                    n_valid  = i_left.valid;
                    n_offset = i_left.offset;
                    n_size   = i_left.size;
                end else if (o_ins) begin
                    n_valid  = 1'b1;
                    n_offset = i_ctl.new_entry.offset;
                    n_size   = i_ctl.new_entry.size;
                end
            end
            wffba_pkg::CH_POP: begin
                n_valid  = i_right.valid;
                n_offset = i_right.offset;
                n_size   = i_right.size;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_offset <= n_offset;
        r_size   <= n_size;
    end

endmodule

/* sv/wffba_chain.sv */
module wffba_chain (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wffba_pkg::t_chain_ctl  i_ctl,
    output wffba_pkg::t_chain_stat o_stat
);

    localparam int unsigned LAST = wffba_pkg::FREE_SLOTS - 1;

    wffba_pkg::t_entry w_entry [wffba_pkg::FREE_SLOTS];
    logic              w_ins   [wffba_pkg::FREE_SLOTS];

    for (genvar g = 0; g < wffba_pkg::FREE_SLOTS; g++) begin : g_cell
        wffba_pkg::t_entry w_left;
        wffba_pkg::t_entry w_right;
        logic              w_left_ins;

        if (g == 0) begin : g_first
            assign w_left     = '0;
            assign w_left_ins = 1'b0;
        end else begin : g_mid
            assign w_left     = w_entry[g-1];
            assign w_left_ins = w_ins[g-1];
        end

        if (g == LAST) begin : g_last
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        wffba_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_left     (w_left),
            .i_left_ins (w_left_ins),
            .i_right    (w_right),
            .o_entry    (w_entry[g]),
            .o_ins      (w_ins[g])
        );
    end

    assign o_stat.head = w_entry[0];
    assign o_stat.full = w_entry[LAST].valid;

endmodule

/* sv/worst_fit_free_block_allocator_top.sv */
// Worst-fit free-block allocator.
// Input channel (i_in_valid / o_in_ready, i_in_item): cmd 0 allocates length
// bytes, cmd 1 frees a block of length bytes at position.
// Output channel (o_out_valid / i_out_ready, o_out_item): one item per request
// with the allocated offset and the reused, dropped and end_wrapped flags.
// Free blocks sit in a row of 16 cells sorted by size, largest at the head;
// an insert or a head removal shifts the whole row in parallel.
// An item is taken in IDLE, then executed in EXEC once the output register
// is free; its result is registered there. An allocation that splits a free
// block reinserts the remainder in REINS. New items are taken only in IDLE.
// i_cfg_we loads the initial end offset and the end pointer; write it only
// while idle.
// Reset (i_rst_n, synchronous, active low) empties the table and clears the
// end pointer. When the receiver stalls, the result waits in the output
// register; execution of the next item waits until that register is free.
module worst_fit_free_block_allocator_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  wffba_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output wffba_pkg::t_out_item o_out_item
);

    wffba_pkg::t_state      r_state;
    wffba_pkg::t_state      n_state;
    wffba_pkg::t_in_item    r_item;
    wffba_pkg::t_entry      r_rem;
    wffba_pkg::t_entry      n_rem;
    logic [31:0]            r_end;
    logic [31:0]            n_end;
    logic                   r_out_valid;
    wffba_pkg::t_out_item   r_out;
    wffba_pkg::t_out_item   n_out;
    logic                   w_load_out;
    logic                   w_out_free;
    logic                   w_hit;
    logic [15:0]            w_rem_size;
    logic [32:0]            w_end_sum;
    wffba_pkg::t_chain_ctl  w_ctl;
    wffba_pkg::t_chain_stat w_stat;

    wffba_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_hit      = w_stat.head.valid && (w_stat.head.size >= r_item.length);
    assign w_rem_size = w_stat.head.size - r_item.length;
    assign w_end_sum  = {1'b0, r_end} + {17'd0, r_item.length}
                      + 33'(wffba_pkg::HDR_BYTES);

    always_comb begin
        n_state = r_state;
        case (r_state)
            wffba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = wffba_pkg::S_EXEC;
                end
            end
            wffba_pkg::S_EXEC: begin
                if (w_out_free) begin
                    if (r_item.cmd == wffba_pkg::CMD_ALLOC && w_hit && w_rem_size != 16'd0) begin
                        n_state = wffba_pkg::S_REINS;
                    end else begin
                        n_state = wffba_pkg::S_IDLE;
                    end
                end
            end
            wffba_pkg::S_REINS: begin
                n_state = wffba_pkg::S_IDLE;
            end
            default: begin
                n_state = wffba_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        w_load_out      = 1'b0;
        w_ctl.op        = wffba_pkg::CH_HOLD;
        w_ctl.new_entry = r_rem;
        n_rem           = r_rem;
        n_end           = r_end;
        n_out           = '0;
        case (r_state)
            wffba_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
            end
            wffba_pkg::S_EXEC: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    if (r_item.cmd == wffba_pkg::CMD_FREE) begin
                        w_ctl.op               = wffba_pkg::CH_INSERT;
                        w_ctl.new_entry.valid  = 1'b1;
                        w_ctl.new_entry.offset = r_item.position;
                        w_ctl.new_entry.size   = r_item.length;
                        n_out.dropped          = w_stat.full;
                    end else if (w_hit) begin
                        w_ctl.op           = wffba_pkg::CH_POP;
                        n_out.alloc_offset = w_stat.head.offset;
                        n_out.reused       = 1'b1;
                        n_rem.valid        = 1'b1;
                        n_rem.offset       = w_stat.head.offset + {16'd0, r_item.length}
                                           + 32'(wffba_pkg::HDR_BYTES);
                        n_rem.size         = w_rem_size;
                    end else begin
                        n_out.alloc_offset = r_end;
                        if (w_end_sum[32]) begin
                            n_end             = '1;
                            n_out.end_wrapped = 1'b1;
                        end else begin
                            n_end = w_end_sum[31:0];
                        end
                    end
                end
            end
            wffba_pkg::S_REINS: begin
                w_ctl.op = wffba_pkg::CH_INSERT;
            end
            default: begin
            end
        endcase
        if (i_cfg_we) begin
            n_end = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wffba_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_end       <= '0;
        end else begin
            r_state <= n_state;
            r_end   <= n_end;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_item;
        end
        if (w_load_out) begin
            r_out <= n_out;
        end
        r_rem <= n_rem;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* tb/sv/worst_fit_free_block_allocator_top_tb.sv */
`timescale 1ns / 100ps

module worst_fit_free_block_allocator_top_tb;

    localparam int unsigned CLK_PERIOD   = 12;
    localparam int unsigned RST_CYCLES   = 7;
    localparam int unsigned SETTLE       = 4;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned LONG_HOLD    = 120;
    localparam int unsigned PHASE_ITEMS  = 256;
    localparam int unsigned QUIET_AFTER  = 900;
    localparam int unsigned NUM_DIRECTED = 25;

    typedef struct {
        logic        cmd;
        logic [15:0] len;
        logic [31:0] pos;
        bit          typed;
        logic [31:0] off;
        bit          reu;
        bit          drp;
        bit          wrp;
    } t_req_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [31:0]          i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_ready;
    wffba_pkg::t_in_item  i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    wffba_pkg::t_out_item o_out_item;

    worst_fit_free_block_allocator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // free-block table mirror, largest first
    logic [31:0] blk_off [wffba_pkg::FREE_SLOTS];
    logic [15:0] blk_size[wffba_pkg::FREE_SLOTS];
    int unsigned blk_count;
    logic [31:0] end_ptr;

    wffba_pkg::t_out_item pending_grants[$];
    int unsigned mismatches;
    int unsigned grant_idx;
    int unsigned sent_cnt;
    int unsigned alloc_cnt;
    int unsigned reuse_cnt;
    int unsigned drop_cnt;
    int unsigned wrap_cnt;
    int unsigned cfg_cnt;
    int unsigned stall_cycles;
    int unsigned hold_asked;
    int unsigned hold_served;
    bit          quiet;

    t_req_row directed_reqs[NUM_DIRECTED] = '{
        '{wffba_pkg::CMD_ALLOC, 16'h0000, 32'h0000_0000, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 1, 32'h0000_0004, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'd100,  32'h0000_1000, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_ALLOC, 16'd100,  32'h0000_0000, 1, 32'h0000_1000, 1, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'hFFFF, 32'hFFFF_FFF0, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_ALLOC, 16'h0010, 32'h0000_0000, 1, 32'hFFFF_FFF0, 1, 0, 0},
        '{wffba_pkg::CMD_ALLOC, 16'h0000, 32'h0000_0000, 1, 32'h0000_0004, 1, 0, 0},
        '{wffba_pkg::CMD_ALLOC, 16'hFFFF, 32'h0000_0000, 0, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0000, 32'h0000_2000, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0800, 32'h0000_0100, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0800, 32'h0000_0200, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0400, 32'h0000_0300, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0001, 32'h0000_0400, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0400, 32'h0000_0500, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h8000, 32'h0000_0600, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0001, 32'h0000_0700, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0200, 32'h0000_0800, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0100, 32'h0000_0900, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0010, 32'h0000_0A00, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0020, 32'h0000_0B00, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0040, 32'h0000_0C00, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0080, 32'h0000_0D00, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0800, 32'h0000_0E00, 1, 32'h0000_0000, 0, 0, 0},
        '{wffba_pkg::CMD_FREE,  16'h0000, 32'h0000_3000, 1, 32'h0000_0000, 0, 1, 0},
        '{wffba_pkg::CMD_FREE,  16'h0300, 32'h0000_4000, 1, 32'h0000_0000, 0, 1, 0}
    };

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    function automatic bit table_place(logic [31:0] off, logic [15:0] size);
        int unsigned pos;
        int unsigned i;
        bit drop;
        pos  = 0;
        drop = 1'b0;
        while (pos < blk_count && blk_size[pos] > size) pos++;
        if (blk_count == wffba_pkg::FREE_SLOTS) begin
            drop = 1'b1;
            if (pos >= wffba_pkg::FREE_SLOTS) return drop;
            blk_count = wffba_pkg::FREE_SLOTS - 1;
        end
        for (i = blk_count; i > pos; i--) begin
            blk_off[i]  = blk_off[i - 1];
            blk_size[i] = blk_size[i - 1];
        end
        blk_off[pos]  = off;
        blk_size[pos] = size;
        blk_count++;
        return drop;
    endfunction

    function automatic wffba_pkg::t_out_item alloc_outcome(wffba_pkg::t_in_item req);
        wffba_pkg::t_out_item res;
        logic [15:0]          rem;
        logic [32:0]          nxt;
        int unsigned          i;
        res = '0;
        if (req.cmd == wffba_pkg::CMD_FREE) begin
            res.dropped = table_place(req.position, req.length);
        end else if (blk_count > 0 && blk_size[0] >= req.length) begin
            rem              = blk_size[0] - req.length;
            res.alloc_offset = blk_off[0];
            res.reused       = 1'b1;
            for (i = 1; i < blk_count; i++) begin
                blk_off[i - 1]  = blk_off[i];
                blk_size[i - 1] = blk_size[i];
            end
            blk_count--;
            if (rem != 0)
                void'(table_place(res.alloc_offset + 32'(req.length)
                                  + 32'(wffba_pkg::HDR_BYTES), rem));
        end else begin
            nxt = {1'b0, end_ptr} + 33'(req.length) + 33'(wffba_pkg::HDR_BYTES);
            res.alloc_offset = end_ptr;
            if (nxt[32]) begin
                end_ptr         = 32'hFFFF_FFFF;
                res.end_wrapped = 1'b1;
            end else begin
                end_ptr = nxt[31:0];
            end
        end
        return res;
    endfunction

    function automatic wffba_pkg::t_in_item random_req();
        wffba_pkg::t_in_item r;
        int unsigned         k;
        r.cmd = ($urandom_range(0, 99) < 45) ? wffba_pkg::CMD_FREE : wffba_pkg::CMD_ALLOC;
        k = $urandom_range(0, 99);
        if (k < 55)
            r.length = 16'($urandom_range(0, 64));
        else if (k < 80)
            r.length = 16'($urandom_range(0, 2048));
        else if (k < 95)
            r.length = 16'($urandom);
        else
            r.length = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(0, 3) == 0)
            r.position = 32'hFFFF_0000 | 32'($urandom_range(0, 65535));
        else
            r.position = $urandom;
        return r;
    endfunction

    task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch result %0d %s: got %h want %h", grant_idx, field, got, want);
        mismatches++;
    endtask

    task automatic offer(wffba_pkg::t_in_item req, bit typed,
                         wffba_pkg::t_out_item typed_res);
        wffba_pkg::t_out_item want;
        if (!quiet && hold_asked == hold_served && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        want = alloc_outcome(req);
        if (typed) want = typed_res;
        sent_cnt++;
        if (req.cmd == wffba_pkg::CMD_ALLOC) alloc_cnt++;
        if (want.reused) reuse_cnt++;
        if (want.dropped) drop_cnt++;
        if (want.end_wrapped) wrap_cnt++;
        pending_grants.push_back(want);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_grants.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_end(logic [31:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        end_ptr = v;
        cfg_cnt++;
    endtask

    // output checker
    always @(posedge i_clk) begin
        wffba_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_grants.size() == 0) begin
                flag_mismatch("unexpected item", o_out_item.alloc_offset, 32'h0);
            end else begin
                want = pending_grants.pop_front();
                if (o_out_item.alloc_offset !== want.alloc_offset)
                    flag_mismatch("alloc_offset", o_out_item.alloc_offset, want.alloc_offset);
                if (o_out_item.reused !== want.reused)
                    flag_mismatch("reused", 32'(o_out_item.reused), 32'(want.reused));
                if (o_out_item.dropped !== want.dropped)
                    flag_mismatch("dropped", 32'(o_out_item.dropped), 32'(want.dropped));
                if (o_out_item.end_wrapped !== want.end_wrapped)
                    flag_mismatch("end_wrapped", 32'(o_out_item.end_wrapped),
                                  32'(want.end_wrapped));
            end
            grant_idx++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", stall_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // receiver
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_asked != hold_served) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_served++;
                i_out_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    // stimulus
    initial begin
        wffba_pkg::t_in_item  req;
        wffba_pkg::t_out_item typed_res;
        logic [31:0]          end_settings[4];
        int unsigned          ph;
        int unsigned          n;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        quiet        = 1'b0;
        mismatches   = 0;
        grant_idx    = 0;
        sent_cnt     = 0;
        alloc_cnt    = 0;
        reuse_cnt    = 0;
        drop_cnt     = 0;
        wrap_cnt     = 0;
        cfg_cnt      = 0;
        stall_cycles = 0;
        hold_asked   = 0;
        hold_served  = 0;
        blk_count    = 0;
        end_ptr      = '0;
        for (int i = 0; i < wffba_pkg::FREE_SLOTS; i++) begin
            blk_off[i]  = '0;
            blk_size[i] = '0;
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: starts from the reset end pointer
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            req.cmd                   = directed_reqs[i].cmd;
            req.length                = directed_reqs[i].len;
            req.position              = directed_reqs[i].pos;
            typed_res.alloc_offset    = directed_reqs[i].off;
            typed_res.reused          = directed_reqs[i].reu;
            typed_res.dropped         = directed_reqs[i].drp;
            typed_res.end_wrapped     = directed_reqs[i].wrp;
            offer(req, directed_reqs[i].typed, typed_res);
        end
        drain();

        end_settings[0] = 32'hFFFF_FFFF;
        end_settings[1] = 32'hFFFF_F000;
        end_settings[2] = 32'h0000_0000;
        end_settings[3] = $urandom;

        for (ph = 0; ph < 4; ph++) begin
            set_end(end_settings[ph]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == 10) hold_asked++;
                if (sent_cnt >= QUIET_AFTER) quiet = 1'b1;
                // the receiver's long hold runs without input gaps
                offer(random_req(), 1'b0, typed_res);
            end
            drain();
        end

        repeat (2 * SETTLE) @(posedge i_clk);
        while (pending_grants.size() > 0) begin
            void'(pending_grants.pop_front());
            flag_mismatch("missing item", 32'h0, 32'h0);
        end

        $display("%0d requests, %0d allocations: %0d reused a free block, %0d appended",
                 sent_cnt, alloc_cnt, reuse_cnt, alloc_cnt - reuse_cnt);
        $display("%0d free-table overflows, %0d end saturations, %0d end offset settings",
                 drop_cnt, wrap_cnt, cfg_cnt);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
sv/wffba_pkg.sv
sv/wffba_cell.sv
sv/wffba_chain.sv
sv/worst_fit_free_block_allocator_top.sv
tb/sv/worst_fit_free_block_allocator_top_tb.sv
